@@ design/uscal_pkg.sv @@
`default_nettype none

package uscal_pkg;

   // Field widths of the two channels
   localparam int SECS_W    = 32;
   localparam int YEAR_W    = 12;
   localparam int MONTH_W   = 4;
   localparam int DAY_W     = 5;
   localparam int HOUR_W    = 5;
   localparam int MINUTE_W  = 6;
   localparam int SECOND_W  = 6;
   localparam int WEEKDAY_W = 3;
   localparam int YDAY_W    = 9;

   localparam int NUM_STAGES = 8;

   typedef logic [15:0] days_type;    // days since the epoch, at most 49710
   typedef logic [16:0] sod_type;     // second of the day
   typedef logic [17:0] doe_type;     // day of the 400-year era
   typedef logic [8:0]  yoe_type;     // year of the era
   typedef logic [8:0]  doy_type;     // day of the March-based year
   typedef logic [3:0]  mp_type;      // March-based month, March is 0

   // Reciprocals: floor(x / d) == (x * RECIP) >> SHIFT over the full operand range
   localparam logic [25:0] DAY_RECIP   = 26'd50903317;   // 1 / 675, x < 2**25
   localparam int          DAY_SHIFT   = 35;
   localparam logic [9:0]  DAY_ODD     = 10'd675;        // 86400 >> 7
   localparam logic [17:0] HOUR_RECIP  = 18'd149131;     // 1 / 3600
   localparam int          HOUR_SHIFT  = 29;
   localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
   localparam logic [12:0] MIN_RECIP   = 13'd4370;       // 1 / 60
   localparam int          MIN_SHIFT   = 18;
   localparam logic [11:0] SECS_PER_MIN = 12'd60;
   localparam logic [16:0] WDAY_RECIP  = 17'd74899;      // 1 / 7
   localparam int          WDAY_SHIFT  = 19;
   localparam logic [15:0] DAYS_PER_WEEK = 16'd7;
   localparam logic [15:0] EPOCH_WEEKDAY = 16'd4;        // Thursday
   localparam logic [17:0] Y1460_RECIP = 18'd183861;     // 1 / 1460
   localparam int          Y1460_SHIFT = 28;
   localparam logic [17:0] Y365_RECIP  = 18'd183860;     // 1 / 365
   localparam int          Y365_SHIFT  = 26;
   localparam logic [11:0] MP_RECIP    = 12'd3427;       // 1 / 153
   localparam int          MP_SHIFT    = 19;

   // Era selection: days + 719468 is in era 4 or era 5
   localparam days_type    ERA5_FIRST_DAY = 16'd11017;   // 5 * 146097 - 719468
   localparam doe_type     ERA4_DOE_OFS   = 18'd135080;  // 719468 - 4 * 146097
   localparam logic [11:0] ERA4_YEAR      = 12'd1600;
   localparam logic [11:0] ERA5_YEAR      = 12'd2000;

   localparam doe_type     CENTURY_DAYS   = 18'd36524;
   localparam doe_type     ERA_LAST_DOE   = 18'd146096;
   localparam doe_type     DAYS_PER_YEAR  = 18'd365;
   localparam yoe_type     YEARS_PER_CENT = 9'd100;

   localparam mp_type      MP_JANUARY     = 4'd10;
   localparam doy_type     JAN1_DOY       = 9'd306;      // March 1 to January 1
   localparam doy_type     MAR1_YDAY      = 9'd59;       // January 1 to March 1, common year

   // First day of each March-based month: (153 * mp + 2) / 5
   function automatic doy_type month_start(input mp_type mp);
      doy_type first;
      case (mp)
         4'd0:    first = 9'd0;
         4'd1:    first = 9'd31;
         4'd2:    first = 9'd61;
         4'd3:    first = 9'd92;
         4'd4:    first = 9'd122;
         4'd5:    first = 9'd153;
         4'd6:    first = 9'd184;
         4'd7:    first = 9'd214;
         4'd8:    first = 9'd245;
         4'd9:    first = 9'd275;
         4'd10:   first = 9'd306;
         4'd11:   first = 9'd337;
         default: first = 9'd0;
      endcase
      return first;
   endfunction

endpackage

`default_nettype wire

@@ design/uscal_ifs.sv @@
`default_nettype none

interface uscal_req_if import uscal_pkg::*;;
   logic              valid;
   logic              ready;
   logic [SECS_W-1:0] unix_seconds;

   modport source (output valid, output unix_seconds, input ready);
   modport sink   (input valid, input unix_seconds, output ready);
endinterface

interface uscal_rsp_if import uscal_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [YEAR_W-1:0]    year;
   logic [MONTH_W-1:0]   month;
   logic [DAY_W-1:0]     day;
   logic [HOUR_W-1:0]    hour;
   logic [MINUTE_W-1:0]  minute;
   logic [SECOND_W-1:0]  second;
   logic [WEEKDAY_W-1:0] weekday;
   logic [YDAY_W-1:0]    day_of_year;

   modport source (output valid, output year, output month, output day, output hour,
                   output minute, output second, output weekday, output day_of_year,
                   input ready);
   modport sink   (input valid, input year, input month, input day, input hour,
                   input minute, input second, input weekday, input day_of_year,
                   output ready);
endinterface

`default_nettype wire

@@ design/unix_seconds_to_calendar_top.sv @@
`default_nettype none
// Throughput: one word per cycle unless rsp_chan stalls; the eight pipeline stages
//    each hold one word, and each stage advances whenever it is empty or the stage
//    after it advances.
// Reset (synchronous, active high) clears the stage valid bits only; data registers
//    keep whatever they hold and are never seen until a valid word reaches them.

module unix_seconds_to_calendar_top import uscal_pkg::*; (
   input wire logic  clock,
   input wire logic  reset,
   uscal_req_if.sink   req_chan,
   uscal_rsp_if.source rsp_chan
);

   // ------------------------------------------------------------------
   // Pipeline control: one valid bit per stage, advance ripples backward
   // from the response port so a stall holds every full stage in place.
   // ------------------------------------------------------------------
   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] vld_in;
   logic [NUM_STAGES-1:0] adv;

   always_comb begin
      adv[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || rsp_chan.ready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
      vld_in[0] = adv[0] ? req_chan.valid : vld_ff[0];
      for (int i = 1; i < NUM_STAGES; i++) begin
         vld_in[i] = adv[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_chan.ready = adv[0];
   assign rsp_chan.valid = vld_ff[NUM_STAGES-1];

   // ------------------------------------------------------------------
   // Stage 1: days = (t >> 7) / 675 by reciprocal multiply.
   // ------------------------------------------------------------------
   logic [SECS_W-1:0] s1_t_ff,    s1_t_in;
   logic [50:0]       s1_pday_ff, s1_pday_in;

   assign s1_t_in    = req_chan.unix_seconds;
   assign s1_pday_in = 51'(req_chan.unix_seconds[31:7]) * 51'(DAY_RECIP);

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s1_t_ff    <= s1_t_in;
         s1_pday_ff <= s1_pday_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: pick the day count, form days * 675 for the remainder.
   // ------------------------------------------------------------------
   days_type          s2_days_ff, s2_days_in;
   logic [25:0]       s2_prem_ff, s2_prem_in;
   logic [SECS_W-1:0] s2_t_ff;

   assign s2_days_in = s1_pday_ff[50:DAY_SHIFT];
   assign s2_prem_in = 26'(s2_days_in) * 26'(DAY_ODD);

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s2_days_ff <= s2_days_in;
         s2_prem_ff <= s2_prem_in;
         s2_t_ff    <= s1_t_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: second of the day, era and day of era, weekday quotient.
   // The shifted day count days + 719468 always lands in era 4 or 5.
   // ------------------------------------------------------------------
   logic [24:0] s3_rdiff;
   days_type    s3_wd4;
   sod_type     s3_sod_ff,  s3_sod_in;
   logic        s3_era5_ff, s3_era5_in;
   doe_type     s3_doe_ff,  s3_doe_in;
   days_type    s3_wd4_ff;
   logic [32:0] s3_pwq_ff,  s3_pwq_in;

   assign s3_rdiff   = s2_t_ff[31:7] - s2_prem_ff[24:0];
   assign s3_sod_in  = {s3_rdiff[9:0], s2_t_ff[6:0]};
   assign s3_era5_in = (s2_days_ff >= ERA5_FIRST_DAY);
   assign s3_doe_in  = s3_era5_in ? (18'(s2_days_ff) - 18'(ERA5_FIRST_DAY))
                                  : (18'(s2_days_ff) + ERA4_DOE_OFS);
   assign s3_wd4     = s2_days_ff + EPOCH_WEEKDAY;
   assign s3_pwq_in  = 33'(s3_wd4) * 33'(WDAY_RECIP);

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         s3_sod_ff  <= s3_sod_in;
         s3_era5_ff <= s3_era5_in;
         s3_doe_ff  <= s3_doe_in;
         s3_wd4_ff  <= s3_wd4;
         s3_pwq_ff  <= s3_pwq_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: weekday, hour product, doe / 1460 product, century count.
   // ------------------------------------------------------------------
   logic [13:0]          s4_wq;
   days_type             s4_wdiff;
   logic [WEEKDAY_W-1:0] s4_weekday_ff, s4_weekday_in;
   logic [34:0]          s4_phour_ff,   s4_phour_in;
   logic [35:0]          s4_pq1460_ff,  s4_pq1460_in;
   logic [2:0]           s4_cent_ff,    s4_cent_in;
   logic                 s4_elast_ff,   s4_elast_in;
   sod_type              s4_sod_ff;
   doe_type              s4_doe_ff;
   logic                 s4_era5_ff;

   assign s4_wq         = s3_pwq_ff[32:WDAY_SHIFT];
   assign s4_wdiff      = s3_wd4_ff - (16'(s4_wq) * DAYS_PER_WEEK);
   assign s4_weekday_in = s4_wdiff[WEEKDAY_W-1:0];
   assign s4_phour_in   = 35'(s3_sod_ff) * 35'(HOUR_RECIP);
   assign s4_pq1460_in  = 36'(s3_doe_ff) * 36'(Y1460_RECIP);
   assign s4_cent_in    = 3'(s3_doe_ff >= CENTURY_DAYS)
                        + 3'(s3_doe_ff >= 18'(2 * CENTURY_DAYS))
                        + 3'(s3_doe_ff >= 18'(3 * CENTURY_DAYS))
                        + 3'(s3_doe_ff >= 18'(4 * CENTURY_DAYS));
   assign s4_elast_in   = (s3_doe_ff == ERA_LAST_DOE);

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         s4_weekday_ff <= s4_weekday_in;
         s4_phour_ff   <= s4_phour_in;
         s4_pq1460_ff  <= s4_pq1460_in;
         s4_cent_ff    <= s4_cent_in;
         s4_elast_ff   <= s4_elast_in;
         s4_sod_ff     <= s3_sod_ff;
         s4_doe_ff     <= s3_doe_ff;
         s4_era5_ff    <= s3_era5_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 5: hour, hour * 3600, corrected day of era times 1/365.
   // ------------------------------------------------------------------
   logic [HOUR_W-1:0]    s5_hour_ff,   s5_hour_in;
   logic [16:0]          s5_ph3600_ff, s5_ph3600_in;
   logic [7:0]           s5_q1460;
   doe_type              s5_adj;
   logic [35:0]          s5_pyoe_ff,   s5_pyoe_in;
   sod_type              s5_sod_ff;
   doe_type              s5_doe_ff;
   logic                 s5_era5_ff;
   logic [WEEKDAY_W-1:0] s5_weekday_ff;

   assign s5_hour_in   = s4_phour_ff[33:HOUR_SHIFT];
   assign s5_ph3600_in = 17'(s5_hour_in) * SECS_PER_HOUR;
   assign s5_q1460     = s4_pq1460_ff[35:Y1460_SHIFT];
   assign s5_adj       = s4_doe_ff - 18'(s5_q1460) + 18'(s4_cent_ff) - 18'(s4_elast_ff);
   assign s5_pyoe_in   = 36'(s5_adj) * 36'(Y365_RECIP);

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         s5_hour_ff    <= s5_hour_in;
         s5_ph3600_ff  <= s5_ph3600_in;
         s5_pyoe_ff    <= s5_pyoe_in;
         s5_sod_ff     <= s4_sod_ff;
         s5_doe_ff     <= s4_doe_ff;
         s5_era5_ff    <= s4_era5_ff;
         s5_weekday_ff <= s4_weekday_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 6: second of the hour, minute product, year of era, day of
   // the March-based year, leap flag of the March-based year.
   // ------------------------------------------------------------------
   sod_type              s6_hdiff;
   logic [11:0]          s6_soh_ff,  s6_soh_in;
   logic [24:0]          s6_pmin_ff, s6_pmin_in;
   yoe_type              s6_yoe_ff,  s6_yoe_in;
   logic [1:0]           s6_c100;
   doe_type              s6_ybase;
   doe_type              s6_ddiff;
   doy_type              s6_doy_ff,  s6_doy_in;
   logic                 s6_leap_ff, s6_leap_in;
   logic                 s6_era5_ff;
   logic [WEEKDAY_W-1:0] s6_weekday_ff;
   logic [HOUR_W-1:0]    s6_hour_ff;

   assign s6_hdiff   = s5_sod_ff - s5_ph3600_ff;
   assign s6_soh_in  = s6_hdiff[11:0];
   assign s6_pmin_in = 25'(s6_soh_in) * 25'(MIN_RECIP);
   assign s6_yoe_in  = s5_pyoe_ff[34:Y365_SHIFT];
   assign s6_c100    = 2'(s6_yoe_in >= YEARS_PER_CENT)
                     + 2'(s6_yoe_in >= 9'(2 * YEARS_PER_CENT))
                     + 2'(s6_yoe_in >= 9'(3 * YEARS_PER_CENT));
   assign s6_ybase   = 18'(s6_yoe_in) * DAYS_PER_YEAR + 18'(s6_yoe_in[8:2]) - 18'(s6_c100);
   assign s6_ddiff   = s5_doe_ff - s6_ybase;
   assign s6_doy_in  = s6_ddiff[8:0];
   // Era base is a multiple of 400, so only the century years inside the era drop out
   assign s6_leap_in = (s6_yoe_in[1:0] == 2'b00)
                    && (s6_yoe_in != YEARS_PER_CENT)
                    && (s6_yoe_in != 9'(2 * YEARS_PER_CENT))
                    && (s6_yoe_in != 9'(3 * YEARS_PER_CENT));

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         s6_soh_ff     <= s6_soh_in;
         s6_pmin_ff    <= s6_pmin_in;
         s6_yoe_ff     <= s6_yoe_in;
         s6_doy_ff     <= s6_doy_in;
         s6_leap_ff    <= s6_leap_in;
         s6_era5_ff    <= s5_era5_ff;
         s6_weekday_ff <= s5_weekday_ff;
         s6_hour_ff    <= s5_hour_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 7: minute and second, March-based month product.
   // ------------------------------------------------------------------
   logic [MINUTE_W-1:0]  s7_minute_ff, s7_minute_in;
   logic [11:0]          s7_mdiff;
   logic [SECOND_W-1:0]  s7_second_ff, s7_second_in;
   logic [10:0]          s7_mpx;
   logic [22:0]          s7_pmp_ff,    s7_pmp_in;
   yoe_type              s7_yoe_ff;
   doy_type              s7_doy_ff;
   logic                 s7_leap_ff;
   logic                 s7_era5_ff;
   logic [WEEKDAY_W-1:0] s7_weekday_ff;
   logic [HOUR_W-1:0]    s7_hour_ff;

   assign s7_minute_in = s6_pmin_ff[23:MIN_SHIFT];
   assign s7_mdiff     = s6_soh_ff - (12'(s7_minute_in) * SECS_PER_MIN);
   assign s7_second_in = s7_mdiff[SECOND_W-1:0];
   assign s7_mpx       = 11'(s6_doy_ff) * 11'd5 + 11'd2;
   assign s7_pmp_in    = 23'(s7_mpx) * 23'(MP_RECIP);

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         s7_minute_ff  <= s7_minute_in;
         s7_second_ff  <= s7_second_in;
         s7_pmp_ff     <= s7_pmp_in;
         s7_yoe_ff     <= s6_yoe_ff;
         s7_doy_ff     <= s6_doy_ff;
         s7_leap_ff    <= s6_leap_ff;
         s7_era5_ff    <= s6_era5_ff;
         s7_weekday_ff <= s6_weekday_ff;
         s7_hour_ff    <= s6_hour_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 8 (output register): undo the March shift.
   // January and February belong to the next calendar year.
   // ------------------------------------------------------------------
   mp_type               s8_mp;
   logic                 s8_janfeb;
   doy_type              s8_dom;
   logic [YEAR_W-1:0]    s8_year_ff,    s8_year_in;
   logic [MONTH_W-1:0]   s8_month_ff,   s8_month_in;
   logic [DAY_W-1:0]     s8_day_ff,     s8_day_in;
   logic [YDAY_W-1:0]    s8_yday_ff,    s8_yday_in;
   logic [HOUR_W-1:0]    s8_hour_ff;
   logic [MINUTE_W-1:0]  s8_minute_ff;
   logic [SECOND_W-1:0]  s8_second_ff;
   logic [WEEKDAY_W-1:0] s8_weekday_ff;

   assign s8_mp       = s7_pmp_ff[22:MP_SHIFT];
   assign s8_janfeb   = (s8_mp >= MP_JANUARY);
   assign s8_dom      = s7_doy_ff - month_start(s8_mp) + 9'd1;
   assign s8_day_in   = s8_dom[DAY_W-1:0];
   assign s8_month_in = s8_janfeb ? (s8_mp - (MP_JANUARY - 4'd1)) : (s8_mp + 4'd3);
   assign s8_year_in  = 12'(s7_yoe_ff) + (s7_era5_ff ? ERA5_YEAR : ERA4_YEAR)
                      + 12'(s8_janfeb);
   assign s8_yday_in  = s8_janfeb ? (s7_doy_ff - JAN1_DOY)
                                  : (s7_doy_ff + MAR1_YDAY + 9'(s7_leap_ff));

   always_ff @(posedge clock) begin
      if (adv[7]) begin
         s8_year_ff    <= s8_year_in;
         s8_month_ff   <= s8_month_in;
         s8_day_ff     <= s8_day_in;
         s8_yday_ff    <= s8_yday_in;
         s8_hour_ff    <= s7_hour_ff;
         s8_minute_ff  <= s7_minute_ff;
         s8_second_ff  <= s7_second_ff;
         s8_weekday_ff <= s7_weekday_ff;
      end
   end

   assign rsp_chan.year        = s8_year_ff;
   assign rsp_chan.month       = s8_month_ff;
   assign rsp_chan.day         = s8_day_ff;
   assign rsp_chan.hour        = s8_hour_ff;
   assign rsp_chan.minute      = s8_minute_ff;
   assign rsp_chan.second      = s8_second_ff;
   assign rsp_chan.weekday     = s8_weekday_ff;
   assign rsp_chan.day_of_year = s8_yday_ff;

endmodule

`default_nettype wire

@@ design/uscal_checker.sv @@
`default_nettype none

module uscal_checker import uscal_pkg::*; (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic [YEAR_W-1:0]    year,
   input wire logic [MONTH_W-1:0]   month,
   input wire logic [DAY_W-1:0]     day,
   input wire logic [HOUR_W-1:0]    hour,
   input wire logic [MINUTE_W-1:0]  minute,
   input wire logic [SECOND_W-1:0]  second,
   input wire logic [WEEKDAY_W-1:0] weekday,
   input wire logic [YDAY_W-1:0]    day_of_year
);

   // Nothing comes out in the cycle after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response word valid right after reset");

   // A stalled response word holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(year) && $stable(month)
         && $stable(day) && $stable(hour) && $stable(minute) && $stable(second)
         && $stable(weekday) && $stable(day_of_year))
      else $error("stalled response word changed");

   // Every field stays inside its calendar range
   a_ranges: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> year >= 12'd1970 && year <= 12'd2106 && month >= 4'd1
         && month <= 4'd12 && day >= 5'd1 && day <= 5'd31 && hour <= 5'd23
         && minute <= 6'd59 && second <= 6'd59 && weekday <= 3'd6
         && day_of_year <= 9'd365)
      else $error("response field out of range");

   // With the sink always ready, an accepted word shows up at the output
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && rsp_ready) ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready
         ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready |=> rsp_valid)
      else $error("accepted word did not reach the output in time");

endmodule

bind unix_seconds_to_calendar_top uscal_checker u_uscal_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .year        (rsp_chan.year),
   .month       (rsp_chan.month),
   .day         (rsp_chan.day),
   .hour        (rsp_chan.hour),
   .minute      (rsp_chan.minute),
   .second      (rsp_chan.second),
   .weekday     (rsp_chan.weekday),
   .day_of_year (rsp_chan.day_of_year)
);

`default_nettype wire
